// ----- design/gaussian_blur_9x9_zero_pad_assert.svh -----
// Assertion macros for the blur design; gbz_back includes them.
`ifndef GAUSSIAN_BLUR_9X9_ZERO_PAD_ASSERT_SVH
`define GAUSSIAN_BLUR_9X9_ZERO_PAD_ASSERT_SVH
`ifndef SYNTH
// check a property on every rising clock edge outside reset
`define GBZ_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gbz: assertion failed");
// check a property on every rising clock edge, reset included
`define GBZ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gbz: assertion failed");
`else
`define GBZ_ASSERT_RST(label, clk, rst, prop)
`define GBZ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- design/gbz_pkg.sv -----
// Types, constants and weight table of the 9x9 Gaussian blur.
package gbz_pkg;

  localparam int PIX_W          = 16;
  localparam int KSIZE          = 9;
  localparam int HALF           = 4;
  localparam int SLOTS          = 8;
  localparam int IMG_W_BITS     = 11;
  localparam int IMG_H_BITS     = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int MAX_HEIGHT     = 4096;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int Q_DEPTH        = 4;
  localparam int COEF_W         = 11;
  localparam int PSUM_W         = PIX_W + 2;
  localparam int PROD_W         = PSUM_W + COEF_W;
  localparam int ROW_W          = PROD_W + 3;
  localparam int ACC_W          = ROW_W + 3;
  localparam int RND_BITS       = 16;
  localparam logic [10:0] IMG_W_RESET = 11'd640;
  localparam logic [12:0] IMG_H_RESET = 13'd480;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  // one quadrant of the symmetric kernel, Q0.16
  localparam logic [COEF_W-1:0] QUARTER_W [5][5] = '{
    '{11'd149, 11'd261,  11'd390,  11'd495,  11'd536},
    '{11'd261, 11'd457,  11'd682,  11'd867,  11'd939},
    '{11'd390, 11'd682,  11'd1017, 11'd1293, 11'd1401},
    '{11'd495, 11'd867,  11'd1293, 11'd1644, 11'd1781},
    '{11'd536, 11'd939,  11'd1401, 11'd1781, 11'd1929}
  };

  // one classified input column handed from front to back
  typedef struct packed {
    logic [KSIZE-1:0][PIX_W-1:0] col;      // index 8 is the newest row
    logic                        clear;    // first column of a row
    logic                        last_col; // last column: four zero shifts follow
    logic [HALF:0]               emit;     // result released at step s
    logic                        lof;      // step four is the frame's last pixel
  } col_entry_t;

endpackage

// ----- design/gbz_pix_if.sv -----
// Pixel input channel.
interface gbz_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- design/gbz_blur_if.sv -----
// Blurred result channel.
interface gbz_blur_if;
  logic        valid;
  logic        ready;
  logic [15:0] blurred_value;
  logic        last_in_run;
  logic        last_of_frame;

  modport source (output valid, output blurred_value, output last_in_run,
                  output last_of_frame, input ready);
  modport sink   (input valid, input blurred_value, input last_in_run,
                  input last_of_frame, output ready);
endinterface

// ----- design/gbz_front.sv -----
// Front end: configuration, raster counters, row store and column build.
module gbz_front #(
  parameter int MAX_WIDTH  = gbz_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gbz_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  gbz_pkg::cfg_index_t               cfg_index,
  input  logic [gbz_pkg::CFG_DATA_W-1:0]    cfg_data,
  gbz_pix_if.sink                           pix_in,
  output logic                              push_valid,
  input  logic                              push_ready,
  output gbz_pkg::col_entry_t               push_entry
);
  import gbz_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = ($clog2(MAX_WIDTH) + 1 > IMG_W_BITS) ? $clog2(MAX_WIDTH) + 1
                                                            : IMG_W_BITS;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic [CW-1:0]         w_eff;
  logic [IMG_H_BITS-1:0] h_eff;
  logic [IMG_H_BITS-1:0] h_end;
  logic [CW-1:0]         input_col;
  logic [IMG_H_BITS-1:0] input_row;
  logic [CW-1:0]         c_eff;
  logic [IMG_H_BITS-1:0] r_eff;
  logic [CW-1:0]         col_next;
  logic [IMG_H_BITS-1:0] row_next;
  logic                  accept;
  logic                  is_last_col;
  logic [PIX_W-1:0]      pix_eff;
  logic [HALF:0]         emit_now;

  logic [SLOTS*PIX_W-1:0] row_store [MAX_WIDTH];
  logic [SLOTS*PIX_W-1:0] rd_data;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [2:0]       s1_slot;
  logic             s1_top;
  logic             s1_clear;
  logic             s1_last;
  logic [HALF:0]    s1_emit;
  logic             s1_lof;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_RESET;
      image_height <= IMG_H_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the registers to the usable range
  always_comb begin
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(image_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = IMG_H_BITS'(1);
    end else if (image_height > IMG_H_BITS'(MAX_HEIGHT)) begin
      h_eff = IMG_H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    h_end = h_eff + IMG_H_BITS'(HALF);
  end

  // position of this item, restarting when out of range
  always_comb begin
    if (input_col >= w_eff || input_row >= h_end) begin
      c_eff = '0;
      r_eff = '0;
    end else begin
      c_eff = input_col;
      r_eff = input_row;
    end
    is_last_col = (c_eff == w_eff - CW'(1));
    if (is_last_col) begin
      col_next = '0;
      row_next = (r_eff + IMG_H_BITS'(1) >= h_end) ? '0 : r_eff + IMG_H_BITS'(1);
    end else begin
      col_next = c_eff + CW'(1);
      row_next = r_eff;
    end
    pix_eff = (r_eff < h_eff) ? (pix_in.pixel_value & PIX_MASK) : '0;
    for (int s = 0; s <= HALF; s++) begin
      emit_now[s] = (r_eff >= IMG_H_BITS'(HALF)) && (c_eff >= CW'(HALF - s));
    end
  end

  assign pix_in.ready = !s1_valid || push_ready;
  assign accept       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_col <= '0;
      input_row <= '0;
    end else if (accept) begin
      input_col <= col_next;
      input_row <= row_next;
    end
  end

  // row store: one word per column, one lane per row slot
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= row_store[c_eff[AW-1:0]];
      row_store[c_eff[AW-1:0]][r_eff[2:0]*PIX_W +: PIX_W] <= pix_eff;
    end
  end

  // stage holding the item while its row store word is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pix_eff;
      s1_slot  <= r_eff[2:0];
      s1_top   <= (r_eff < IMG_H_BITS'(SLOTS));
      s1_clear <= (c_eff == '0);
      s1_last  <= is_last_col;
      s1_emit  <= emit_now;
      s1_lof   <= is_last_col && (r_eff == h_end - IMG_H_BITS'(1));
    end
  end

  // assemble the column, rows above the image read as zero
  always_comb begin
    logic [3:0] pos;
    for (int k = 0; k < SLOTS; k++) begin
      pos = {1'b0, s1_slot} + 4'(k);
      if (s1_top && pos < 4'(SLOTS)) begin
        push_entry.col[k] = '0;
      end else begin
        push_entry.col[k] = rd_data[pos[2:0]*PIX_W +: PIX_W];
      end
    end
    push_entry.col[KSIZE-1] = s1_pix;
    push_entry.clear        = s1_clear;
    push_entry.last_col     = s1_last;
    push_entry.emit         = s1_emit;
    push_entry.lof          = s1_lof;
  end

  assign push_valid = s1_valid;

endmodule

// ----- design/gbz_queue.sv -----
// Short queue of classified columns between front and back.
module gbz_queue #(
  parameter int DEPTH = gbz_pkg::Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  gbz_pkg::col_entry_t push_entry,
  output logic                head_valid,
  input  logic                pop,
  output gbz_pkg::col_entry_t head
);
  import gbz_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  col_entry_t     slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != NW'(DEPTH));
  assign head_valid = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

// ----- design/gbz_back.sv -----
// Back end: sliding window, zero flush at row end, pipelined weighted sum.
`include "gaussian_blur_9x9_zero_pad_assert.svh"
module gbz_back #(
  parameter int PIXEL_BITS = gbz_pkg::DEF_PIXEL_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  gbz_pkg::col_entry_t head,
  output logic                pop,
  gbz_blur_if.source          blur_out
);
  import gbz_pkg::*;

  localparam logic [ACC_W-RND_BITS-1:0] MAX_OUT =
    (ACC_W-RND_BITS)'((33'd1 << PIXEL_BITS) - 33'd1);

  logic             adv;
  logic [2:0]       step;
  logic             last_step;
  logic             take;
  logic [PIX_W-1:0] win [KSIZE][KSIZE];

  logic              a_valid, a_lir, a_lof;
  logic              b_valid, b_lir, b_lof;
  logic              c_valid, c_lir, c_lof;
  logic              d_valid, d_lir, d_lof;
  logic [PSUM_W-1:0] b_sum  [5][5];
  logic [PROD_W-1:0] c_prod [5][5];
  logic [ROW_W-1:0]  d_row  [5];
  logic [ROW_W-1:0]  row_acc [5];
  logic [ACC_W-1:0]  total;
  logic [ACC_W-RND_BITS-1:0] rounded;
  logic [PIX_W-1:0]  result;

  // the whole pipeline moves when the output register can take a result
  assign adv       = !blur_out.valid || blur_out.ready;
  assign last_step = !head.last_col || (step == 3'(HALF));
  assign take      = adv && head_valid;
  assign pop       = take && last_step;

  // step through the column and its zero flush
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (take) begin
      step <= last_step ? '0 : step + 3'd1;
    end
  end

  // sliding window, newest column at the right
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < KSIZE; k++) begin
        for (int l = 0; l < KSIZE - 1; l++) begin
          win[k][l] <= (step == '0 && head.clear) ? '0 : win[k][l+1];
        end
        win[k][KSIZE-1] <= (step == '0) ? head.col[k] : '0;
      end
    end
  end

  // fold the symmetric window onto one quadrant
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= HALF; k++) begin
        for (int l = 0; l <= HALF; l++) begin
          logic [PIX_W:0] left;
          logic [PIX_W:0] right;
          left  = (PIX_W+1)'(win[k][l]);
          right = (PIX_W+1)'(win[k][KSIZE-1-l]);
          if (k < HALF) begin
            left  = left + (PIX_W+1)'(win[KSIZE-1-k][l]);
            right = right + (PIX_W+1)'(win[KSIZE-1-k][KSIZE-1-l]);
          end
          b_sum[k][l] <= (l < HALF) ? PSUM_W'(left) + PSUM_W'(right) : PSUM_W'(left);
        end
      end
    end
  end

  // constant weight products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= HALF; k++) begin
        for (int l = 0; l <= HALF; l++) begin
          c_prod[k][l] <= PROD_W'(b_sum[k][l]) * PROD_W'(QUARTER_W[k][l]);
        end
      end
    end
  end

  // row partial sums
  always_comb begin
    for (int k = 0; k <= HALF; k++) begin
      row_acc[k] = '0;
      for (int l = 0; l <= HALF; l++) begin
        row_acc[k] = row_acc[k] + ROW_W'(c_prod[k][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= HALF; k++) begin
        d_row[k] <= row_acc[k];
      end
    end
  end

  // final sum, round half up, saturate
  always_comb begin
    total = ACC_W'(1) << (RND_BITS - 1);
    for (int k = 0; k <= HALF; k++) begin
      total = total + ACC_W'(d_row[k]);
    end
    rounded = total[ACC_W-1:RND_BITS];
    result  = (rounded > MAX_OUT) ? PIX_W'(MAX_OUT) : PIX_W'(rounded);
  end

  // flags travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      blur_out.valid <= 1'b0;
    end else if (adv) begin
      a_valid <= take && head.emit[step];
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      blur_out.valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_lir <= last_step;
      a_lof <= head.lof && (step == 3'(HALF));
      b_lir <= a_lir;
      b_lof <= a_lof;
      c_lir <= b_lir;
      c_lof <= b_lof;
      d_lir <= c_lir;
      d_lof <= c_lof;
      blur_out.blurred_value <= result;
      blur_out.last_in_run   <= d_lir;
      blur_out.last_of_frame <= d_lof;
    end
  end

  `GBZ_ASSERT_RST(a_step_idle, clk, rst, !head_valid |-> step == 3'd0)
  `GBZ_ASSERT_RST(a_step_bound, clk, rst, step != 3'd0 |-> head.last_col && step <= 3'(HALF))
  `GBZ_ASSERT_RST(a_lof_ends_run, clk, rst,
                  blur_out.valid && blur_out.last_of_frame |-> blur_out.last_in_run)

endmodule

// ----- design/gaussian_blur_9x9_zero_pad.sv -----
// 9x9 Gaussian blur with zero padding: top level.
//
// Pixels enter on pix_in in raster order, one transfer each; after the
// image rows the source sends four more rows of image_width items, whose
// values are ignored. Results leave on blur_out; the result for pixel (r,c)
// is released by input (r+4, min(c+4, W-1)), so the last column of a row
// releases up to five results. last_in_run marks the final result released
// by an input, last_of_frame the result for the bottom-right pixel.
// image_width and image_height must be written on the cfg port only while
// idle; the block does not enforce this. Throughput: one pixel per cycle
// unless blur_out stalls or the queue fills during the back end's zero
// flush of the window at each row end. An input's first result passes the
// front stage, queue, window and stages a to d into the blur_out register.
// A four-entry column queue separates the row store front end from the
// window and adder pipeline, so each side stalls on its own.
// When blur_out is stalled the pipeline holds; pix_in keeps taking items
// until the queue fills. Reset restores 640x480, clears the counters and
// empties the pipeline; the row store needs no clearing.
module gaussian_blur_9x9_zero_pad #(
  parameter int MAX_WIDTH  = gbz_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gbz_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  gbz_pkg::cfg_index_t            cfg_index,
  input  logic [gbz_pkg::CFG_DATA_W-1:0] cfg_data,
  gbz_pix_if.sink                        pix_in,
  gbz_blur_if.source                     blur_out
);
  import gbz_pkg::*;

  logic       push_valid;
  logic       push_ready;
  col_entry_t push_entry;
  logic       head_valid;
  logic       pop;
  col_entry_t head;

  gbz_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_in     (pix_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  gbz_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  gbz_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .blur_out   (blur_out)
  );

endmodule
